[design/rcp_pkg.sv]
// Shared types, constants and saturation helper for the radial camera projection.
package rcp_pkg;

    // Default number of fraction bits of every coordinate (Q16.16)
    localparam int COORD_FRAC_BITS_DEF = 16;
    // Fraction bits of the radial coefficient (Q4.28)
    localparam int K_FRAC_BITS = 28;
    localparam int COORD_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    // Working width for values checked against the signed 32-bit range
    localparam int SAT_W       = 72;

    localparam logic signed [SAT_W-1:0] MAX32 = 72'sh0000_0000_007F_FF_FFFF;
    localparam logic signed [SAT_W-1:0] MIN32 = -72'sh0000_0000_0080_00_0000;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_DEPTH = 2'd1,
        ST_SATURATED  = 2'd2
    } status_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_FOCAL    = 2'd0,
        REG_CENTER_X = 2'd1,
        REG_CENTER_Y = 2'd2,
        REG_RADIAL   = 2'd3
    } reg_idx_t;

    // Control that travels with every item through the pipeline
    typedef struct packed {
        logic valid;
        logic zero;
        logic sat;
    } ctl_t;

    typedef struct packed {
        logic [COORD_W-1:0] value;
        logic               clamped;
    } sat_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
        sat_t r;
        r.value   = v[COORD_W-1:0];
        r.clamped = 1'b0;
        if (v > MAX32) begin
            r.value   = MAX32[COORD_W-1:0];
            r.clamped = 1'b1;
        end else if (v < MIN32) begin
            r.value   = MIN32[COORD_W-1:0];
            r.clamped = 1'b1;
        end
        return r;
    endfunction

endpackage

[design/rcp_norm_div.sv]
// Pipelined signed divider forming the normalized coordinates cam / depth.
module rcp_norm_div #(
    parameter int FRAC = rcp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [rcp_pkg::COORD_W-1:0]          cam_x,
    input  logic [rcp_pkg::COORD_W-1:0]          cam_y,
    input  logic [rcp_pkg::COORD_W-1:0]          depth,
    output logic signed [rcp_pkg::COORD_W-1:0]   nx,
    output logic signed [rcp_pkg::COORD_W-1:0]   ny,
    output rcp_pkg::ctl_t                        ctl_o
);
    import rcp_pkg::*;

    // One quotient bit per stage
    localparam int W = COORD_W + FRAC;

    logic [W-1:0]       q_reg    [2][W+1];
    logic [COORD_W-1:0] r_reg    [2][W+1];
    logic               neg_reg  [2][W+1];
    logic [COORD_W-1:0] d_reg    [W+1];
    logic               zero_reg [W+1];
    logic               vld_reg  [W+1];

    logic [COORD_W-1:0] mag_x, mag_y, mag_d;
    sat_t               sat_x, sat_y;
    logic signed [SAT_W-1:0] qs_x, qs_y;

    logic signed [COORD_W-1:0] nx_reg, ny_reg;
    ctl_t                      ctl_reg;

    // Magnitudes for unsigned restoring division
    always_comb begin
        mag_x = cam_x[COORD_W-1] ? (~cam_x + 1'b1) : cam_x;
        mag_y = cam_y[COORD_W-1] ? (~cam_y + 1'b1) : cam_y;
        mag_d = depth[COORD_W-1] ? (~depth + 1'b1) : depth;
    end

    // Entry stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0][0]   <= {mag_x, {FRAC{1'b0}}};
            q_reg[1][0]   <= {mag_y, {FRAC{1'b0}}};
            r_reg[0][0]   <= '0;
            r_reg[1][0]   <= '0;
            neg_reg[0][0] <= cam_x[COORD_W-1] ^ depth[COORD_W-1];
            neg_reg[1][0] <= cam_y[COORD_W-1] ^ depth[COORD_W-1];
            d_reg[0]      <= mag_d;
            zero_reg[0]   <= (depth == '0);
        end
    end

    // Division steps
    for (genvar i = 0; i < W; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[i+1]    <= d_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [COORD_W:0] trial;
            logic [COORD_W:0] diff;
            logic             ge;

            assign trial = {r_reg[l][i], q_reg[l][i][W-1]};
            assign diff  = trial - {1'b0, d_reg[i]};
            assign ge    = (trial >= {1'b0, d_reg[i]});

            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[l][i+1]   <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
                    q_reg[l][i+1]   <= {q_reg[l][i][W-2:0], ge};
                    neg_reg[l][i+1] <= neg_reg[l][i];
                end
            end
        end
    end

    // Apply sign and clamp to 32 bits
    always_comb begin
        qs_x  = neg_reg[0][W] ? -$signed(SAT_W'(q_reg[0][W])) : $signed(SAT_W'(q_reg[0][W]));
        qs_y  = neg_reg[1][W] ? -$signed(SAT_W'(q_reg[1][W])) : $signed(SAT_W'(q_reg[1][W]));
        sat_x = sat32(qs_x);
        sat_y = sat32(qs_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= vld_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg       <= $signed(sat_x.value);
            ny_reg       <= $signed(sat_y.value);
            ctl_reg.zero <= zero_reg[W];
            ctl_reg.sat  <= sat_x.clamped | sat_y.clamped;
        end
    end

    assign nx    = nx_reg;
    assign ny    = ny_reg;
    assign ctl_o = ctl_reg;

    // Restoring division keeps the partial remainder below the divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[W] && d_reg[W] != '0) |->
            (r_reg[0][W] < d_reg[W] && r_reg[1][W] < d_reg[W]))
        else $error("partial remainder not below divisor");

endmodule

[design/rcp_distort.sv]
// Radial distortion stages: r2, scale factor and distorted coordinates.
module rcp_distort #(
    parameter int FRAC = rcp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  rcp_pkg::ctl_t                        ctl_i,
    input  logic signed [rcp_pkg::COORD_W-1:0]   nx,
    input  logic signed [rcp_pkg::COORD_W-1:0]   ny,
    input  logic [rcp_pkg::COORD_W-1:0]          radial_coeff,
    output logic signed [rcp_pkg::COORD_W-1:0]   ux,
    output logic signed [rcp_pkg::COORD_W-1:0]   uy,
    output rcp_pkg::ctl_t                        ctl_o
);
    import rcp_pkg::*;

    localparam logic signed [SAT_W-1:0] ONE = SAT_W'(1) <<< FRAC;

    // Stage registers
    ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;
    ctl_t ctl3_next, ctl4_next, ctl6_next;

    logic signed [COORD_W-1:0] nx1_reg, ny1_reg, nx2_reg, ny2_reg;
    logic signed [COORD_W-1:0] nx3_reg, ny3_reg, nx4_reg, ny4_reg;
    logic [2*COORD_W-1:0]      sqx_reg, sqy_reg;
    logic [COORD_W-1:0]        r2_reg;
    logic                      r2of_reg;
    logic signed [2*COORD_W-1:0] prod_reg;
    logic signed [COORD_W-1:0] s_reg;
    logic signed [2*COORD_W-1:0] mx_reg, my_reg;
    logic signed [COORD_W-1:0] ux_reg, uy_reg;

    logic signed [2*COORD_W-1:0] sqx_full, sqy_full;
    logic [2*COORD_W-1:0]      sum, sum_sh;
    logic signed [2*COORD_W:0] prod_full;
    logic signed [2*COORD_W-1:0] rad;
    sat_t                      s_sat, ux_sat, uy_sat;

    // Full-width squares of the normalized coordinates
    always_comb begin
        sqx_full = nx * nx;
        sqy_full = ny * ny;
    end

    // r2 sum, shift and clamp
    always_comb begin
        sum    = sqx_reg + sqy_reg;
        sum_sh = sum >> FRAC;
    end

    // k * r2 and scale factor
    always_comb begin
        prod_full = $signed(radial_coeff) * $signed({1'b0, r2_reg});
        ctl3_next = ctl2_reg;
        ctl3_next.sat = ctl2_reg.sat | (r2of_reg && radial_coeff != '0);
        rad       = prod_reg >>> K_FRAC_BITS;
        s_sat     = sat32(SAT_W'(rad) + ONE);
        ctl4_next = ctl3_reg;
        ctl4_next.sat = ctl3_reg.sat | s_sat.clamped;
    end

    // Distorted coordinates
    always_comb begin
        ux_sat    = sat32(SAT_W'(mx_reg >>> FRAC));
        uy_sat    = sat32(SAT_W'(my_reg >>> FRAC));
        ctl6_next = ctl5_reg;
        ctl6_next.sat = ctl5_reg.sat | ux_sat.clamped | uy_sat.clamped;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
            ctl2_reg.valid <= 1'b0;
            ctl3_reg.valid <= 1'b0;
            ctl4_reg.valid <= 1'b0;
            ctl5_reg.valid <= 1'b0;
            ctl6_reg.valid <= 1'b0;
        end else if (en) begin
            ctl1_reg.valid <= ctl_i.valid;
            ctl2_reg.valid <= ctl1_reg.valid;
            ctl3_reg.valid <= ctl3_next.valid;
            ctl4_reg.valid <= ctl4_next.valid;
            ctl5_reg.valid <= ctl4_reg.valid;
            ctl6_reg.valid <= ctl6_next.valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            // squares
            sqx_reg  <= $unsigned(sqx_full);
            sqy_reg  <= $unsigned(sqy_full);
            nx1_reg  <= nx;
            ny1_reg  <= ny;
            {ctl1_reg.zero, ctl1_reg.sat} <= {ctl_i.zero, ctl_i.sat};
            // r2
            r2_reg   <= (|sum_sh[2*COORD_W-1:COORD_W]) ? '1 : sum_sh[COORD_W-1:0];
            r2of_reg <= |sum_sh[2*COORD_W-1:COORD_W];
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            {ctl2_reg.zero, ctl2_reg.sat} <= {ctl1_reg.zero, ctl1_reg.sat};
            // k * r2
            prod_reg <= prod_full[2*COORD_W-1:0];
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            {ctl3_reg.zero, ctl3_reg.sat} <= {ctl3_next.zero, ctl3_next.sat};
            // scale factor
            s_reg    <= $signed(s_sat.value);
            nx4_reg  <= nx3_reg;
            ny4_reg  <= ny3_reg;
            {ctl4_reg.zero, ctl4_reg.sat} <= {ctl4_next.zero, ctl4_next.sat};
            // coordinate times scale
            mx_reg   <= nx4_reg * s_reg;
            my_reg   <= ny4_reg * s_reg;
            {ctl5_reg.zero, ctl5_reg.sat} <= {ctl4_reg.zero, ctl4_reg.sat};
            // rescale and clamp
            ux_reg   <= $signed(ux_sat.value);
            uy_reg   <= $signed(uy_sat.value);
            {ctl6_reg.zero, ctl6_reg.sat} <= {ctl6_next.zero, ctl6_next.sat};
        end
    end

    assign ux    = ux_reg;
    assign uy    = uy_reg;
    assign ctl_o = ctl6_reg;

endmodule

[design/rcp_pixel.sv]
// Focal scaling, principal point offset and result status.
module rcp_pixel #(
    parameter int FRAC = rcp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  rcp_pkg::ctl_t                        ctl_i,
    input  logic signed [rcp_pkg::COORD_W-1:0]   ux,
    input  logic signed [rcp_pkg::COORD_W-1:0]   uy,
    input  logic [rcp_pkg::COORD_W-1:0]          focal_length,
    input  logic [rcp_pkg::COORD_W-1:0]          center_x,
    input  logic [rcp_pkg::COORD_W-1:0]          center_y,
    output logic                                 out_valid,
    output logic [rcp_pkg::COORD_W-1:0]          pixel_x,
    output logic [rcp_pkg::COORD_W-1:0]          pixel_y,
    output rcp_pkg::status_t                     status
);
    import rcp_pkg::*;

    ctl_t                        ctl1_reg;
    logic signed [2*COORD_W-1:0] fx_reg, fy_reg;
    logic signed [2*COORD_W:0]   fx_full, fy_full;
    sat_t                        px_sat, py_sat;

    logic                        valid_reg;
    logic [COORD_W-1:0]          px_reg, py_reg;
    status_t                     status_reg;
    status_t                     status_next;

    // Focal multiply
    always_comb begin
        fx_full = $signed({1'b0, focal_length}) * ux;
        fy_full = $signed({1'b0, focal_length}) * uy;
    end

    // Offset, clamp and status
    always_comb begin
        px_sat = sat32(SAT_W'(fx_reg >>> FRAC) + $signed(SAT_W'(center_x)));
        py_sat = sat32(SAT_W'(fy_reg >>> FRAC) + $signed(SAT_W'(center_y)));
        if (ctl1_reg.zero) begin
            status_next = ST_ZERO_DEPTH;
        end else if (ctl1_reg.sat || px_sat.clamped || py_sat.clamped) begin
            status_next = ST_SATURATED;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
            valid_reg      <= 1'b0;
        end else if (en) begin
            ctl1_reg.valid <= ctl_i.valid;
            valid_reg      <= ctl1_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg     <= fx_full[2*COORD_W-1:0];
            fy_reg     <= fy_full[2*COORD_W-1:0];
            {ctl1_reg.zero, ctl1_reg.sat} <= {ctl_i.zero, ctl_i.sat};
            // zero depth forces a zero pixel
            px_reg     <= ctl1_reg.zero ? '0 : px_sat.value;
            py_reg     <= ctl1_reg.zero ? '0 : py_sat.value;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign status    = status_reg;

endmodule

[design/radial_camera_projection.sv]
// Top level of the radial camera projection: stream ports, registers, pipeline.
//
//  Channel  | Ports                       | Item
//  ---------+-----------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata   | cam_x, cam_y, depth (Q.F signed)
//  result   | m_tvalid m_tready m_tdata   | pixel_x, pixel_y; status on m_tuser
//  config   | psel penable pwrite paddr   | focal_length, center_x, center_y,
//           | pwdata prdata pready        | radial_coeff at 0x0, 0x4, 0x8, 0xC
//
// One item per cycle unless a result waits on m_tready; Q16.16 by default. Stages in order:
// divider entry, one quotient bit per divider stage (32 + COORD_FRAC_BITS stages),
// divider output, six distortion and two pixel stages.
// Reset is synchronous: it clears the valid bits and loads the register defaults.
// A result waiting on m_tready holds the whole pipeline in place, bubbles included.
module radial_camera_projection #(
    parameter int COORD_FRAC_BITS = rcp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [3*rcp_pkg::COORD_W-1:0]        s_tdata,  // cam_x, cam_y, depth
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [2*rcp_pkg::COORD_W-1:0]        m_tdata,  // pixel_x, pixel_y
    output logic [rcp_pkg::STATUS_W-1:0]         m_tuser,  // status
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rcp_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [rcp_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [rcp_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import rcp_pkg::*;

    logic [COORD_W-1:0] focal_reg, cx_reg, cy_reg, k_reg;
    reg_idx_t           addr_idx;
    logic               cfg_wr;

    logic                      en;
    ctl_t                      div_ctl, dist_ctl;
    logic signed [COORD_W-1:0] nx, ny, ux, uy;
    logic                      pix_valid;
    logic [COORD_W-1:0]        pixel_x, pixel_y;
    status_t                   status;

    // Configuration registers
    assign pready   = 1'b1;
    assign addr_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg <= COORD_W'(32'd65536);
            cx_reg    <= '0;
            cy_reg    <= '0;
            k_reg     <= '0;
        end else if (cfg_wr) begin
            case (addr_idx)
                REG_FOCAL:    focal_reg <= pwdata;
                REG_CENTER_X: cx_reg    <= pwdata;
                REG_CENTER_Y: cy_reg    <= pwdata;
                REG_RADIAL:   k_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (addr_idx)
            REG_FOCAL:    prdata = focal_reg;
            REG_CENTER_X: prdata = cx_reg;
            REG_CENTER_Y: prdata = cy_reg;
            REG_RADIAL:   prdata = k_reg;
            default:      prdata = '0;
        endcase
    end

    // Whole pipeline advances unless a result is waiting on the output
    assign en       = !pix_valid || m_tready;
    assign s_tready = en;

    rcp_norm_div #(.FRAC(COORD_FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .cam_x    (s_tdata[COORD_W-1:0]),
        .cam_y    (s_tdata[2*COORD_W-1:COORD_W]),
        .depth    (s_tdata[3*COORD_W-1:2*COORD_W]),
        .nx       (nx),
        .ny       (ny),
        .ctl_o    (div_ctl)
    );

    rcp_distort #(.FRAC(COORD_FRAC_BITS)) u_distort (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .ctl_i        (div_ctl),
        .nx           (nx),
        .ny           (ny),
        .radial_coeff (k_reg),
        .ux           (ux),
        .uy           (uy),
        .ctl_o        (dist_ctl)
    );

    rcp_pixel #(.FRAC(COORD_FRAC_BITS)) u_pixel (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .ctl_i        (dist_ctl),
        .ux           (ux),
        .uy           (uy),
        .focal_length (focal_reg),
        .center_x     (cx_reg),
        .center_y     (cy_reg),
        .out_valid    (pix_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .status       (status)
    );

    assign m_tvalid = pix_valid;
    assign m_tdata  = {pixel_y, pixel_x};
    assign m_tuser  = status;

    // A zero-depth result carries a zero pixel
    a_zero_depth_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_ZERO_DEPTH) |-> (m_tdata == '0))
        else $error("zero-depth item with nonzero pixel");

    // No result is offered right after reset
    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // Input is taken whenever the output side is free
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !$past(m_tvalid)) |-> s_tready)
        else $error("input blocked with empty output");

endmodule

[sim/tb_radial_camera_projection.sv]
// Self-checking testbench for radial_camera_projection: directed and random points.
module tb_radial_camera_projection;
    import rcp_pkg::*;

    localparam int FRAC         = COORD_FRAC_BITS_DEF;
    localparam int PIPE_LATENCY = FRAC + 42;
    localparam int RUN_LIMIT    = 400000;

    // one camera-frame point and one projected pixel
    typedef struct {
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_y;
        logic signed [COORD_W-1:0] depth;
    } point_t;

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        status_t                   st;
    } pixel_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [3*COORD_W-1:0]          s_tdata  = '0;  // cam_x, cam_y, depth
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [2*COORD_W-1:0]          m_tdata;        // pixel_x, pixel_y
    logic [STATUS_W-1:0]           m_tuser;        // status
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]         paddr    = '0;
    logic [CFG_DATA_W-1:0]         pwdata   = '0;
    logic [CFG_DATA_W-1:0]         prdata;
    logic                          pready;

    // register copy used by the predictor
    logic [31:0] cfg_focal  = 32'h0001_0000;
    logic [31:0] cfg_cx     = '0;
    logic [31:0] cfg_cy     = '0;
    logic [31:0] cfg_radial = '0;

    pixel_t      pixel_q[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b1;
    bit          stall_on       = 1'b1;
    logic [15:0] ready_pat      = 16'hFFFF;
    int          pat_age        = 0;

    radial_camera_projection DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("tb_radial_camera_projection: errors");
        $finish;
    end

    // clamp to signed 32 bits, flag when clamped
    function automatic longint clamp32(input longint v, inout bit hit);
        if (v > 64'sh7FFF_FFFF) begin
            hit = 1'b1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            hit = 1'b1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    // expected pixel for one point under the current registers
    function automatic pixel_t project_point(input point_t p);
        pixel_t          r;
        longint          cx, cy, dz, k, one, nx, ny, rad, scale, ux, uy, fl, ox, oy;
        longint unsigned r2;
        bit              hit;
        cx  = p.cam_x;
        cy  = p.cam_y;
        dz  = p.depth;
        k   = $signed(cfg_radial);
        one = longint'(1) << FRAC;
        hit = 1'b0;
        if (dz == 0) begin
            r.px = '0;
            r.py = '0;
            r.st = ST_ZERO_DEPTH;
            return r;
        end
        // normalize by depth, truncating toward zero
        nx = clamp32((cx * one) / dz, hit);
        ny = clamp32((cy * one) / dz, hit);
        // squared radius, unsigned; clamp only matters with a nonzero k
        r2 = nx * nx;
        r2 = r2 + longint'(ny * ny);
        r2 = r2 >> FRAC;
        if (r2 > 64'hFFFF_FFFF) begin
            r2 = 64'hFFFF_FFFF;
            if (k != 0)
                hit = 1'b1;
        end
        rad   = (k * longint'(r2)) >>> K_FRAC_BITS;
        scale = clamp32(one + rad, hit);
        ux    = clamp32((nx * scale) >>> FRAC, hit);
        uy    = clamp32((ny * scale) >>> FRAC, hit);
        // focal length and principal point, both unsigned
        fl = cfg_focal;
        ox = cfg_cx;
        oy = cfg_cy;
        r.px = COORD_W'(clamp32(((fl * ux) >>> FRAC) + ox, hit));
        r.py = COORD_W'(clamp32(((fl * uy) >>> FRAC) + oy, hit));
        r.st = hit ? ST_SATURATED : ST_OK;
        return r;
    endfunction

    function automatic point_t pt(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] d);
        point_t p;
        p.cam_x = x;
        p.cam_y = y;
        p.depth = d;
        return p;
    endfunction

    // mostly plausible scenes, some raw noise, zero and tiny depths
    function automatic point_t random_point();
        point_t      p;
        int unsigned d;
        case ($urandom_range(0, 9))
            0, 1: begin
                p.cam_x = $urandom();
                p.cam_y = $urandom();
                p.depth = $urandom();
            end
            2: begin
                p.cam_x = $urandom();
                p.cam_y = $urandom();
                p.depth = '0;
            end
            3: begin
                d       = $urandom_range(1, 255);
                p.depth = $urandom_range(0, 1) ? -d : d;
                p.cam_x = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                p.cam_y = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            end
            default: begin
                d       = $urandom_range(32'h0000_8000, 32'h00C8_0000);
                p.cam_x = $urandom_range(0, 4 * d) - 2 * d;
                p.cam_y = $urandom_range(0, 4 * d) - 2 * d;
                p.depth = ($urandom_range(0, 7) == 0) ? -d : d;
            end
        endcase
        return p;
    endfunction

    // receiver: rotating ready pattern, re-drawn each time pat_age wraps to zero
    always @(negedge aclk) begin
        if (pat_age == 0) begin
            if (!stall_on || $urandom_range(0, 3) == 0)
                ready_pat = 16'hFFFF;
            else
                ready_pat = 16'($urandom()) | 16'h0001;
        end
        pat_age   = (pat_age + 1) % 128;
        ready_pat = {ready_pat[0], ready_pat[15:1]};
        m_tready <= ready_pat[0];
    end

    // compare each result item with the oldest expected pixel
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected result item: pixel %h status %0d", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[31:0] !== want.px) begin
                    $error("pixel_x: expected %h, got %h", want.px, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[63:32] !== want.py) begin
                    $error("pixel_y: expected %h, got %h", want.py, m_tdata[63:32]);
                    mismatch_count++;
                end
                if (m_tuser !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // APB write: setup then access; model copy follows the write
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FOCAL:    cfg_focal  = val;
            REG_CENTER_X: cfg_cx     = val;
            REG_CENTER_Y: cfg_cy     = val;
            REG_RADIAL:   cfg_radial = val;
            default: ;
        endcase
    endtask

    task automatic set_optics(input logic [31:0] focal, input logic [31:0] cx,
                              input logic [31:0] cy, input logic [31:0] k);
        write_reg(REG_FOCAL, focal);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIAL, k);
    endtask

    // plausible camera: hundreds of pixels focal, mild distortion
    task automatic random_optics();
        set_optics(($urandom_range(100, 3000) << 16) | $urandom_range(0, 65535),
                   ($urandom_range(0, 2000) << 16) | $urandom_range(0, 65535),
                   ($urandom_range(0, 2000) << 16) | $urandom_range(0, 65535),
                   $urandom_range(0, 32'h0800_0000) - 32'h0400_0000);
    endtask

    // send one point in bursts with random gaps; expectation at acceptance
    task automatic push_point(input point_t p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap        = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {p.depth, p.cam_y, p.cam_x};
        do @(posedge aclk); while (!s_tready);
        pixel_q.push_back(project_point(p));
    endtask

    // hold the sender off until every expected pixel has come back
    task automatic wait_results_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic push_random(input int n);
        repeat (n) push_point(random_point());
    endtask

    // reset register values: unit focal, zero center, no distortion
    task automatic test_reset_defaults();
        push_point(pt(32'h0001_0000, 32'h0002_0000, 32'h0004_0000));
        push_point(pt(32'h1234_5678, 32'h8765_4321, 32'h0000_0000));  // zero depth
        push_point(pt(32'h0003_0000, 32'hFFFE_8000, 32'hFFFE_0000));  // negative depth
        push_point(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));  // saturates
        wait_results_done();
    endtask

    task automatic test_directed();
        set_optics(32'h0320_0000, 32'h0280_0000, 32'h0168_0000, 32'hFE66_6666);
        push_point(pt(32'h0000_0000, 32'h0000_0000, 32'h0001_0000));
        push_point(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_point(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // most negative x over depth of minus one overflows the quotient
        push_point(pt(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
        push_point(pt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_point(pt(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        push_point(pt(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000));
        push_point(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));  // zero depth
        // radius squared beyond 32 bits with distortion on
        push_point(pt(32'h0100_0000, 32'h0100_0000, 32'h0001_0000));
        push_point(pt(32'h0003_0000, 32'h0000_0000, 32'h0001_0000));
        push_point(pt(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000));
        push_point(pt(32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_0000));
        wait_results_done();
        // same huge radius, no distortion: the radius clamp must not flag
        set_optics(32'h0001_0000, 32'h0280_0000, 32'h0168_0000, 32'h0000_0000);
        push_point(pt(32'h0100_0000, 32'h0100_0000, 32'h0001_0000));
        push_point(pt(32'h0100_0000, 32'hFF00_0000, 32'hFFFF_0000));
        wait_results_done();
    endtask

    task automatic test_config_extremes();
        set_optics(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_random(30);
        wait_results_done();
        set_optics(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_random(30);
        wait_results_done();
        set_optics(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        push_random(30);
        wait_results_done();
        set_optics(32'h0400_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'hF000_0000);
        push_random(30);
        wait_results_done();
    endtask

    // full rate on both sides
    task automatic test_back_to_back();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        random_optics();
        push_random(150);
        wait_results_done();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 3)
                set_optics($urandom(), $urandom(), $urandom(), $urandom());
            else
                random_optics();
            push_random(60);
            wait_results_done();
            push_random(60);
            wait_results_done();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_config_extremes();
        test_back_to_back();
        test_random();
        wait_results_done();
        repeat (PIPE_LATENCY + 16) @(posedge aclk);
        if (mismatch_count == 0 && pixel_q.size() == 0)
            $display("tb_radial_camera_projection: clean");
        else
            $display("tb_radial_camera_projection: errors");
        $finish;
    end

endmodule
